// File: rtl/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared types and constants of the two-link inverse kinematics block.
// ----------------------------------------------------------------------------
package tlik_pkg;

   localparam int COORD_W     = 32;
   localparam int LINK_W      = 30;
   localparam int CSR_INDEX_W = 1;
   localparam int WIDE_W      = 64;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [LINK_W-1:0]         link_type;
   typedef logic [CSR_INDEX_W-1:0]    csr_index_type;

   localparam csr_index_type REG_UPPER_LINK = 1'd0;
   localparam csr_index_type REG_LOWER_LINK = 1'd1;

endpackage

// File: rtl/tlik_req_if.sv
// ----------------------------------------------------------------------------
// tlik_req_if
// Request channel: one target point per transfer.
// ----------------------------------------------------------------------------
interface tlik_req_if;
   import tlik_pkg::*;

   logic      valid;
   logic      ready;
   coord_type target_x;
   coord_type target_y;

   modport source (output valid, output target_x, output target_y, input ready);
   modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

// File: rtl/tlik_rsp_if.sv
// ----------------------------------------------------------------------------
// tlik_rsp_if
// Response channel: reach flag and the two elbow solutions.
// ----------------------------------------------------------------------------
interface tlik_rsp_if;
   import tlik_pkg::*;

   logic      valid;
   logic      ready;
   logic      reachable;
   coord_type elbow_a_x;
   coord_type elbow_a_y;
   coord_type elbow_b_x;
   coord_type elbow_b_y;

   modport source (output valid, output reachable, output elbow_a_x, output elbow_a_y,
                   output elbow_b_x, output elbow_b_y, input ready);
   modport sink   (input valid, input reachable, input elbow_a_x, input elbow_a_y,
                   input elbow_b_x, input elbow_b_y, output ready);
endinterface

// File: rtl/two_link_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics
// Elbow positions of a two-link planar arm for a stream of target points.
// ----------------------------------------------------------------------------
// Link lengths are written through the csr_ port (index 0 upper link, index 1
// lower link) while no request is in flight. Each request on req_ch carries a
// target point; each response on rsp_ch carries the reach flag and the elbow
// for both bend directions, zero when the target cannot be reached.
// The datapath is one pipeline of 142 stages: input and squaring stages, a
// 32-stage square root for the distance, a 33-stage divider for the
// projection, a second 32-stage square root for the tangent offset, product
// stages and four 33-stage dividers for the elbow coordinates. One request is
// taken per cycle while no response is held back on rsp_ch.
// Reset clears every valid bit and both link lengths; no response is pending
// after reset. When the receiver holds rsp_ch.ready low with a response
// waiting, the whole pipeline freezes and req_ch.ready drops; nothing is lost
// and nothing is repeated.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics (
   input  logic                    clock,
   input  logic                    reset,
   tlik_req_if.sink                req_ch,
   tlik_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  tlik_pkg::csr_index_type csr_index,
   input  tlik_pkg::link_type      csr_wdata
);
   import tlik_pkg::*;

   typedef struct packed {
      coord_type   x;
      coord_type   y;
      logic [63:0] nmag;
      logic        nneg;
      logic        ok;
      logic [59:0] l1sq;
   } dist_side_type;

   typedef struct packed {
      coord_type   x;
      coord_type   y;
      logic [30:0] d;
      logic        ok;
      logic [59:0] l1sq;
   } proj_side_type;

   typedef struct packed {
      coord_type   x;
      coord_type   y;
      coord_type   p;
      logic [30:0] d;
      logic        ok;
   } tan_side_type;

   link_type upper_ff;
   link_type lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= '0;
         lower_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_UPPER_LINK: upper_ff <= csr_wdata;
            REG_LOWER_LINK: lower_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   logic rsp_valid_ff;
   logic en;

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // Stage 1: capture, magnitudes, link sum and difference.
   logic        v1_ff;
   coord_type   x1_ff, y1_ff;
   logic [31:0] mx1_ff, my1_ff;
   logic [30:0] sum1_ff;
   logic [29:0] diff1_ff;
   link_type    l1_1_ff, l2_1_ff;

   // Stage 2: squares.
   logic        v2_ff;
   coord_type   x2_ff, y2_ff;
   logic [63:0] mxsq2_ff, mysq2_ff;
   logic [61:0] sumsq2_ff, diffsq2_ff;
   logic [59:0] l1sq2_ff, l2sq2_ff;

   // Stage 3: distance squared and link square difference.
   logic        v3_ff;
   coord_type   x3_ff, y3_ff;
   logic [63:0] d2_3_ff;
   logic [61:0] sumsq3_ff, diffsq3_ff;
   logic [59:0] l1sq3_ff;
   logic [60:0] dl3_ff;

   // Stage 4: reach test and projection numerator.
   logic        v4_ff;
   coord_type   x4_ff, y4_ff;
   logic [63:0] d2_4_ff;
   logic [63:0] n4_ff;
   logic        ok4_ff;
   logic [59:0] l1sq4_ff;

   // Stage 5: numerator magnitude.
   logic          v5_ff;
   logic [63:0]   d2_5_ff;
   dist_side_type side5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= req_ch.target_x;
         y1_ff    <= req_ch.target_y;
         mx1_ff   <= req_ch.target_x[31] ? 32'(-req_ch.target_x) : 32'(req_ch.target_x);
         my1_ff   <= req_ch.target_y[31] ? 32'(-req_ch.target_y) : 32'(req_ch.target_y);
         sum1_ff  <= {1'b0, upper_ff} + {1'b0, lower_ff};
         diff1_ff <= (upper_ff >= lower_ff) ? upper_ff - lower_ff : lower_ff - upper_ff;
         l1_1_ff  <= upper_ff;
         l2_1_ff  <= lower_ff;

         x2_ff      <= x1_ff;
         y2_ff      <= y1_ff;
         mxsq2_ff   <= {32'b0, mx1_ff} * {32'b0, mx1_ff};
         mysq2_ff   <= {32'b0, my1_ff} * {32'b0, my1_ff};
         sumsq2_ff  <= {31'b0, sum1_ff} * {31'b0, sum1_ff};
         diffsq2_ff <= {32'b0, diff1_ff} * {32'b0, diff1_ff};
         l1sq2_ff   <= {30'b0, l1_1_ff} * {30'b0, l1_1_ff};
         l2sq2_ff   <= {30'b0, l2_1_ff} * {30'b0, l2_1_ff};

         x3_ff      <= x2_ff;
         y3_ff      <= y2_ff;
         d2_3_ff    <= mxsq2_ff + mysq2_ff;
         sumsq3_ff  <= sumsq2_ff;
         diffsq3_ff <= diffsq2_ff;
         l1sq3_ff   <= l1sq2_ff;
         dl3_ff     <= {1'b0, l1sq2_ff} - {1'b0, l2sq2_ff};

         x4_ff    <= x3_ff;
         y4_ff    <= y3_ff;
         d2_4_ff  <= d2_3_ff;
         n4_ff    <= d2_3_ff + {{3{dl3_ff[60]}}, dl3_ff};
         ok4_ff   <= d2_3_ff != 64'd0 && d2_3_ff <= {2'b0, sumsq3_ff}
                     && d2_3_ff >= {2'b0, diffsq3_ff};
         l1sq4_ff <= l1sq3_ff;

         d2_5_ff       <= d2_4_ff;
         side5_ff.x    <= x4_ff;
         side5_ff.y    <= y4_ff;
         side5_ff.nmag <= n4_ff[63] ? -n4_ff : n4_ff;
         side5_ff.nneg <= n4_ff[63];
         side5_ff.ok   <= ok4_ff;
         side5_ff.l1sq <= l1sq4_ff;
      end
   end

   // Distance to the target.
   logic          dist_valid;
   logic [31:0]   dist_root;
   dist_side_type dist_side;

   tlik_sqrt #(.SIDE_W($bits(dist_side_type))) u_dist_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (v5_ff),
      .in_radicand (d2_5_ff),
      .in_side     (side5_ff),
      .out_valid   (dist_valid),
      .out_root    (dist_root),
      .out_side    (dist_side)
   );

   // Projection of the elbow on the target direction.
   proj_side_type proj_in_side;
   logic          proj_valid;
   coord_type     proj_quot;
   proj_side_type proj_side;

   always_comb begin
      proj_in_side.x    = dist_side.x;
      proj_in_side.y    = dist_side.y;
      proj_in_side.d    = dist_root[30:0];
      proj_in_side.ok   = dist_side.ok;
      proj_in_side.l1sq = dist_side.l1sq;
   end

   tlik_div #(.SIDE_W($bits(proj_side_type))) u_proj_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dist_valid),
      .in_mag    (dist_side.nmag),
      .in_neg    (dist_side.nneg),
      .in_den    ({dist_root[30:0], 1'b0}),
      .in_side   (proj_in_side),
      .out_valid (proj_valid),
      .out_quot  (proj_quot),
      .out_side  (proj_side)
   );

   // Stages 6 to 8: clamp, square and tangent root argument.
   logic          v6_ff, v7_ff, v8_ff;
   proj_side_type side6_ff, side7_ff;
   coord_type     p6_ff, p7_ff;
   logic [30:0]   pmag6_ff;
   logic [61:0]   psq7_ff;
   logic [63:0]   arg8_ff;
   tan_side_type  side8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= proj_valid;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side6_ff <= proj_side;
         if (proj_quot == coord_type'(32'h8000_0000)) begin
            p6_ff    <= coord_type'(32'h8000_0001);
            pmag6_ff <= 31'h7FFF_FFFF;
         end else begin
            p6_ff    <= proj_quot;
            pmag6_ff <= proj_quot[31] ? 31'(-proj_quot) : proj_quot[30:0];
         end

         side7_ff <= side6_ff;
         p7_ff    <= p6_ff;
         psq7_ff  <= {31'b0, pmag6_ff} * {31'b0, pmag6_ff};

         side8_ff.x  <= side7_ff.x;
         side8_ff.y  <= side7_ff.y;
         side8_ff.p  <= p7_ff;
         side8_ff.d  <= side7_ff.d;
         side8_ff.ok <= side7_ff.ok;
         // A rounded projection past the upper link leaves no tangent offset.
         arg8_ff <= (psq7_ff >= {2'b0, side7_ff.l1sq}) ? 64'd0
                    : {4'b0, side7_ff.l1sq - psq7_ff[59:0]};
      end
   end

   logic         tan_valid;
   logic [31:0]  tan_root;
   tan_side_type tan_side;

   tlik_sqrt #(.SIDE_W($bits(tan_side_type))) u_tan_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (v8_ff),
      .in_radicand (arg8_ff),
      .in_side     (side8_ff),
      .out_valid   (tan_valid),
      .out_root    (tan_root),
      .out_side    (tan_side)
   );

   // Stages 9 to 11: products, sums and magnitudes of the four numerators.
   logic              v9_ff, v10_ff, v11_ff;
   logic signed [63:0] xp9_ff, yt9_ff, yp9_ff, xt9_ff;
   logic [63:0]       ax10_ff, ay10_ff, bx10_ff, by10_ff;
   logic [63:0]       axm11_ff, aym11_ff, bxm11_ff, bym11_ff;
   logic              axn11_ff, ayn11_ff, bxn11_ff, byn11_ff;
   logic [30:0]       d9_ff, d10_ff, d11_ff;
   logic              ok9_ff, ok10_ff, ok11_ff;
   coord_type         t_signed;

   assign t_signed = coord_type'({1'b0, tan_root[30:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else if (en) begin
         v9_ff  <= tan_valid;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xp9_ff <= 64'(tan_side.x) * 64'(tan_side.p);
         yt9_ff <= 64'(tan_side.y) * 64'(t_signed);
         yp9_ff <= 64'(tan_side.y) * 64'(tan_side.p);
         xt9_ff <= 64'(tan_side.x) * 64'(t_signed);
         d9_ff  <= tan_side.d;
         ok9_ff <= tan_side.ok;

         ax10_ff <= 64'(xp9_ff + yt9_ff);
         ay10_ff <= 64'(yp9_ff - xt9_ff);
         bx10_ff <= 64'(xp9_ff - yt9_ff);
         by10_ff <= 64'(yp9_ff + xt9_ff);
         d10_ff  <= d9_ff;
         ok10_ff <= ok9_ff;

         axm11_ff <= ax10_ff[63] ? -ax10_ff : ax10_ff;
         aym11_ff <= ay10_ff[63] ? -ay10_ff : ay10_ff;
         bxm11_ff <= bx10_ff[63] ? -bx10_ff : bx10_ff;
         bym11_ff <= by10_ff[63] ? -by10_ff : by10_ff;
         axn11_ff <= ax10_ff[63];
         ayn11_ff <= ay10_ff[63];
         bxn11_ff <= bx10_ff[63];
         byn11_ff <= by10_ff[63];
         d11_ff   <= d10_ff;
         ok11_ff  <= ok10_ff;
      end
   end

   logic      elb_valid;
   logic      elb_ok;
   coord_type ax_q, ay_q, bx_q, by_q;

   tlik_div #(.SIDE_W(1)) u_ax_div (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (v11_ff), .in_mag (axm11_ff), .in_neg (axn11_ff),
      .in_den ({1'b0, d11_ff}), .in_side (ok11_ff),
      .out_valid (elb_valid), .out_quot (ax_q), .out_side (elb_ok)
   );

   tlik_div #(.SIDE_W(1)) u_ay_div (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (v11_ff), .in_mag (aym11_ff), .in_neg (ayn11_ff),
      .in_den ({1'b0, d11_ff}), .in_side (ok11_ff),
      .out_valid (), .out_quot (ay_q), .out_side ()
   );

   tlik_div #(.SIDE_W(1)) u_bx_div (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (v11_ff), .in_mag (bxm11_ff), .in_neg (bxn11_ff),
      .in_den ({1'b0, d11_ff}), .in_side (ok11_ff),
      .out_valid (), .out_quot (bx_q), .out_side ()
   );

   tlik_div #(.SIDE_W(1)) u_by_div (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (v11_ff), .in_mag (bym11_ff), .in_neg (byn11_ff),
      .in_den ({1'b0, d11_ff}), .in_side (ok11_ff),
      .out_valid (), .out_quot (by_q), .out_side ()
   );

   // Output register.
   logic      reach_ff;
   coord_type ax_ff, ay_ff, bx_ff, by_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= elb_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         reach_ff <= elb_ok;
         ax_ff    <= elb_ok ? ax_q : '0;
         ay_ff    <= elb_ok ? ay_q : '0;
         bx_ff    <= elb_ok ? bx_q : '0;
         by_ff    <= elb_ok ? by_q : '0;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.reachable = reach_ff;
   assign rsp_ch.elbow_a_x = ax_ff;
   assign rsp_ch.elbow_a_y = ay_ff;
   assign rsp_ch.elbow_b_x = bx_ff;
   assign rsp_ch.elbow_b_y = by_ff;

   // An unreachable target always reports both elbows at the origin.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.reachable |->
         rsp_ch.elbow_a_x == 0 && rsp_ch.elbow_a_y == 0
         && rsp_ch.elbow_b_x == 0 && rsp_ch.elbow_b_y == 0)
      else $error("unreachable response carries a nonzero elbow");

   // Requests are refused only while a response is held back.
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid && !rsp_ch.ready)
      else $error("request refused without a stalled response");

   // The pipeline comes out of reset empty.
   assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

   // A stalled pipeline does not move items toward the output.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> $stable(v11_ff) && $stable(v5_ff))
      else $error("pipeline advanced during a stall");

endmodule

// File: rtl/tlik_sqrt.sv
// ----------------------------------------------------------------------------
// tlik_sqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module tlik_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [tlik_pkg::WIDE_W-1:0] in_radicand,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [31:0]                out_root,
   output logic [SIDE_W-1:0]          out_side
);
   import tlik_pkg::*;

   localparam int STEPS = WIDE_W / 2;

   logic [WIDE_W-1:0] rem_ff   [STEPS];
   logic [WIDE_W-1:0] root_ff  [STEPS];
   logic [SIDE_W-1:0] side_ff  [STEPS];
   logic              valid_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [WIDE_W-1:0] BIT = WIDE_W'(1) << (WIDE_W - 2 - 2 * k);
      logic [WIDE_W-1:0] rem_src;
      logic [WIDE_W-1:0] root_src;
      logic [WIDE_W-1:0] trial;
      logic [SIDE_W-1:0] side_src;
      logic              valid_src;

      if (k == 0) begin : g_first
         assign rem_src   = in_radicand;
         assign root_src  = '0;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign side_src  = side_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      assign trial = root_src + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_src;
            if (rem_src >= trial) begin
               rem_ff[k]  <= rem_src - trial;
               root_ff[k] <= (root_src >> 1) + BIT;
            end else begin
               rem_ff[k]  <= rem_src;
               root_ff[k] <= root_src >> 1;
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1][31:0];
   assign out_side  = side_ff[STEPS-1];

endmodule

// File: rtl/tlik_div.sv
// ----------------------------------------------------------------------------
// tlik_div
// Pipelined signed division by a positive 32-bit divisor, rounded to nearest
// with ties away from zero and saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
module tlik_div #(
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [tlik_pkg::WIDE_W-1:0] in_mag,
   input  logic                        in_neg,
   input  logic [31:0]                 in_den,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output tlik_pkg::coord_type         out_quot,
   output logic [SIDE_W-1:0]           out_side
);
   import tlik_pkg::*;

   localparam int QBITS = 31;

   // Front stage: a quotient that does not fit in 31 bits saturates anyway.
   logic              f_valid_ff;
   logic              f_ovf_ff;
   logic              f_neg_ff;
   logic [31:0]       f_den_ff;
   logic [31:0]       f_rem_ff;
   logic [QBITS-1:0]  f_low_ff;
   logic [SIDE_W-1:0] f_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ovf_ff  <= in_mag >= {1'b0, in_den, 31'b0};
         f_neg_ff  <= in_neg;
         f_den_ff  <= in_den;
         f_rem_ff  <= in_mag[WIDE_W-2:QBITS];
         f_low_ff  <= in_mag[QBITS-1:0];
         f_side_ff <= in_side;
      end
   end

   logic              valid_ff [QBITS];
   logic              ovf_ff   [QBITS];
   logic              neg_ff   [QBITS];
   logic [31:0]       den_ff   [QBITS];
   logic [31:0]       rem_ff   [QBITS];
   logic [QBITS-1:0]  low_ff   [QBITS];
   logic [QBITS-1:0]  quot_ff  [QBITS];
   logic [SIDE_W-1:0] side_ff  [QBITS];

   for (genvar j = 0; j < QBITS; j++) begin : g_iter
      logic              valid_src;
      logic              ovf_src;
      logic              neg_src;
      logic [31:0]       den_src;
      logic [31:0]       rem_src;
      logic [QBITS-1:0]  low_src;
      logic [QBITS-1:0]  quot_src;
      logic [SIDE_W-1:0] side_src;
      logic [32:0]       shifted;

      if (j == 0) begin : g_first
         assign valid_src = f_valid_ff;
         assign ovf_src   = f_ovf_ff;
         assign neg_src   = f_neg_ff;
         assign den_src   = f_den_ff;
         assign rem_src   = f_rem_ff;
         assign low_src   = f_low_ff;
         assign quot_src  = '0;
         assign side_src  = f_side_ff;
      end else begin : g_next
         assign valid_src = valid_ff[j-1];
         assign ovf_src   = ovf_ff[j-1];
         assign neg_src   = neg_ff[j-1];
         assign den_src   = den_ff[j-1];
         assign rem_src   = rem_ff[j-1];
         assign low_src   = low_ff[j-1];
         assign quot_src  = quot_ff[j-1];
         assign side_src  = side_ff[j-1];
      end

      assign shifted = {rem_src, low_src[QBITS-1-j]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ovf_ff[j]  <= ovf_src;
            neg_ff[j]  <= neg_src;
            den_ff[j]  <= den_src;
            low_ff[j]  <= low_src;
            side_ff[j] <= side_src;
            if (shifted >= {1'b0, den_src}) begin
               rem_ff[j]  <= 32'(shifted - {1'b0, den_src});
               quot_ff[j] <= quot_src | (QBITS'(1) << (QBITS - 1 - j));
            end else begin
               rem_ff[j]  <= shifted[31:0];
               quot_ff[j] <= quot_src;
            end
         end
      end
   end

   logic        round_up;
   logic [31:0] rounded;
   logic [31:0] mag;
   logic        o_valid_ff;
   coord_type   o_quot_ff;
   logic [SIDE_W-1:0] o_side_ff;

   always_comb begin
      round_up = {rem_ff[QBITS-1], 1'b0} >= {1'b0, den_ff[QBITS-1]};
      rounded  = {1'b0, quot_ff[QBITS-1]} + {31'b0, round_up};
      if (neg_ff[QBITS-1]) begin
         mag = (ovf_ff[QBITS-1] || rounded > 32'h8000_0000) ? 32'h8000_0000 : rounded;
      end else begin
         mag = (ovf_ff[QBITS-1] || rounded > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : rounded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= valid_ff[QBITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_quot_ff <= neg_ff[QBITS-1] ? coord_type'(-mag) : coord_type'(mag);
         o_side_ff <= side_ff[QBITS-1];
      end
   end

   assign out_valid = o_valid_ff;
   assign out_quot  = o_quot_ff;
   assign out_side  = o_side_ff;

endmodule
